// ----- src/ssd_pkg.sv -----
// ---------------------------------------------------------------------------
// ssd_pkg: shared types and constants of the seven-segment controller
// Beat layouts, command codes, register indexes and the digit pattern table.
// ---------------------------------------------------------------------------
`default_nettype none
package ssd_pkg;

    // buffer geometry
    localparam int MAX_DIGITS = 8;
    localparam int POS_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // integer conversion: 32-bit magnitude into ten bcd digits, four bits a cycle
    localparam int VALUE_W    = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CONV_BITS  = 4;
    localparam int CONV_STEPS = VALUE_W / CONV_BITS;
    localparam int STEP_W     = $clog2(CONV_STEPS);

    // commands
    localparam logic [1:0] CMD_SCAN  = 2'd0;
    localparam logic [1:0] CMD_BLINK = 2'd1;
    localparam logic [1:0] CMD_WINT  = 2'd2;
    localparam logic [1:0] CMD_WCHR  = 2'd3;

    // register indexes (byte address 8 * index)
    localparam logic [2:0] REG_DIGIT_COUNT = 3'd0;
    localparam logic [2:0] REG_FILL_ZERO   = 3'd1;
    localparam logic [2:0] REG_FRAC_DIGITS = 3'd2;
    localparam logic [2:0] REG_BLINK_EN    = 3'd3;
    localparam logic [2:0] REG_USER_COUNT  = 3'd4;
    localparam logic [2:0] REG_USER_TABLE  = 3'd5;

    // characters
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [6:0] CH7_ZERO      = 7'h30;
    localparam logic [6:0] CH7_NINE      = 7'h39;
    localparam logic [6:0] CH7_MINUS     = 7'h2D;
    localparam logic [6:0] CH7_A         = 7'h41;

    // segment patterns
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_POINT = 8'h80;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
        logic [2:0]  position;
        logic [7:0]  character;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] segments;
        logic [2:0] digit_select;
    } out_beat_t;

    // decimal digit to segments
    function automatic logic [7:0] digit_seg(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0: s = 8'h3F;
            4'd1: s = 8'h06;
            4'd2: s = 8'h5B;
            4'd3: s = 8'h4F;
            4'd4: s = 8'h66;
            4'd5: s = 8'h6D;
            4'd6: s = 8'h7D;
            4'd7: s = 8'h07;
            4'd8: s = 8'h7F;
            4'd9: s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- src/seven_segment_display_controller.sv -----
// ---------------------------------------------------------------------------
// seven_segment_display_controller: multiplexed seven-segment controller
// Scan, blink and write-character beats are taken back to back while idle
// (scans also need a free output); a scan result is registered and shows
// in the cycle after its beat. Write integer runs the bcd converter (4 bits
// a cycle), then a load, a step per integer position written, a final check.
// Synchronous active-low reset: buffer to spaces, scan position 0, display
// on, registers to their reset values.
// ---------------------------------------------------------------------------
`default_nettype none
module seven_segment_display_controller (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input beats
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ssd_pkg::in_beat_t  s_data,
    // result beats
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ssd_pkg::out_beat_t      m_data,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output logic [63:0]             prdata,
    output logic                    pready
);
    import ssd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_FMT  = 2'd2;

    // configuration registers
    logic [3:0]  digit_count_reg;
    logic        fill_zero_reg;
    logic [2:0]  frac_digits_reg;
    logic        blink_en_reg;
    logic [3:0]  user_count_reg;
    logic [63:0] user_table_reg;

    // display state
    logic [7:0]       buf_reg  [MAX_DIGITS];
    logic [7:0]       buf_next [MAX_DIGITS];
    logic [POS_W-1:0] scan_pos_reg;
    logic             blink_phase_reg;
    logic [1:0]       state_reg;

    // output register
    logic      m_valid_reg;
    out_beat_t m_data_reg;

    // formatter state
    logic [BCD_W-1:0] fmt_bcd_reg;
    logic             fmt_minus_reg;
    logic             fmt_fill_reg;
    logic [CNT_W-1:0] fmt_top_reg;
    logic [CNT_W-1:0] fmt_n_reg;
    logic [CNT_W-1:0] idx_reg;

    logic                s_acc;
    logic                cfg_wr;
    logic [CNT_W-1:0]    n_cur;
    logic [CNT_W-1:0]    frac_cur;
    logic [CNT_W-1:0]    top_cur;
    logic [CNT_W-1:0]    pos_inc;
    logic                val_minus;
    logic [VALUE_W-1:0]  val_mag;
    logic                conv_start;
    logic                conv_done;
    logic [BCD_W-1:0]    conv_bcd;
    logic [7:0]          scan_seg;
    logic [CNT_W-1:0]    fmt_low;
    logic                fmt_go;
    logic                fmt_zero;
    logic                fmt_blank;
    logic [CNT_W-1:0]    idx_m1;
    logic [CNT_W-1:0]    n_m1;

    // handshake
    assign s_ready = (state_reg == ST_IDLE) &&
                     (!m_valid_reg || m_ready || s_data.cmd != CMD_SCAN);
    assign s_acc   = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // digits in use and integer field split
    always_comb begin
        n_cur = CNT_W'(digit_count_reg);
        if (digit_count_reg == 4'd0) begin
            n_cur = CNT_W'(1);
        end else if ({1'b0, digit_count_reg} > 5'(MAX_DIGITS)) begin
            n_cur = CNT_W'(MAX_DIGITS);
        end
        frac_cur = CNT_W'(frac_digits_reg);
        if (frac_cur > n_cur - CNT_W'(1)) begin
            frac_cur = n_cur - CNT_W'(1);
        end
        top_cur = n_cur - frac_cur;
    end

    // sign and magnitude of the integer
    assign val_minus  = s_data.value[VALUE_W-1];
    assign val_mag    = val_minus ? (VALUE_W'(0) - s_data.value) : s_data.value;
    assign conv_start = s_acc && (s_data.cmd == CMD_WINT);

    ssd_bcd_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .mag     (val_mag),
        .done    (conv_done),
        .bcd     (conv_bcd)
    );

    ssd_seg_decode u_decode (
        .char_in    (buf_reg[scan_pos_reg]),
        .user_count (user_count_reg),
        .user_table (user_table_reg),
        .seg        (scan_seg)
    );

    assign pos_inc = CNT_W'(scan_pos_reg) + CNT_W'(1);

    // formatter step decisions
    assign fmt_low   = (fmt_fill_reg && fmt_minus_reg) ? CNT_W'(1) : CNT_W'(0);
    assign fmt_go    = idx_reg > fmt_low;
    assign fmt_zero  = (fmt_bcd_reg == '0);
    assign fmt_blank = !fmt_fill_reg && (idx_reg != fmt_top_reg) && fmt_zero;
    assign idx_m1    = idx_reg - CNT_W'(1);
    assign n_m1      = fmt_n_reg - CNT_W'(1);

    // character buffer next value
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            buf_next[i] = buf_reg[i];
        end
        if (s_acc && s_data.cmd == CMD_WCHR) begin
            buf_next[s_data.position[POS_W-1:0]] = s_data.character;
        end
        if (s_acc && s_data.cmd == CMD_WINT) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                if (CNT_W'(i) >= top_cur && CNT_W'(i) < n_cur) begin
                    buf_next[i] = CH_ZERO;
                end
            end
        end
        if (state_reg == ST_FMT) begin
            if (fmt_go) begin
                if (fmt_blank) begin
                    buf_next[idx_m1[POS_W-1:0]] = fmt_minus_reg ? CH_MINUS : CH_SPACE;
                end else begin
                    buf_next[idx_m1[POS_W-1:0]] = CH_ZERO | {4'h0, fmt_bcd_reg[3:0]};
                end
            end else begin
                if (fmt_fill_reg && fmt_minus_reg) begin
                    buf_next[0] = CH_MINUS;
                end
                if (!fmt_zero || (!fmt_fill_reg && fmt_minus_reg)) begin
                    buf_next[n_m1[POS_W-1:0]] = CH_UNDERSCORE;
                end
            end
        end
    end

    // buffer, scan, blink and control state
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                buf_reg[i] <= CH_SPACE;
            end
            scan_pos_reg    <= '0;
            blink_phase_reg <= 1'b1;
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
        end else begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                buf_reg[i] <= buf_next[i];
            end
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_acc && s_data.cmd == CMD_SCAN) begin
                m_valid_reg  <= 1'b1;
                scan_pos_reg <= (pos_inc >= n_cur) ? '0 : pos_inc[POS_W-1:0];
            end
            if (s_acc && s_data.cmd == CMD_BLINK && blink_en_reg) begin
                blink_phase_reg <= !blink_phase_reg;
            end
            if (cfg_wr && paddr[5:3] == REG_BLINK_EN && !pwdata[0]) begin
                blink_phase_reg <= 1'b1;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (conv_start) begin
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (conv_done) begin
                        state_reg <= ST_FMT;
                    end
                end
                ST_FMT: begin
                    if (!fmt_go) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // scan result payload
    always_ff @(posedge aclk) begin
        if (s_acc && s_data.cmd == CMD_SCAN) begin
            m_data_reg.segments     <= blink_phase_reg ? scan_seg : 8'h00;
            m_data_reg.digit_select <= 3'(scan_pos_reg);
        end
    end

    // formatter payload
    always_ff @(posedge aclk) begin
        if (conv_start) begin
            fmt_minus_reg <= val_minus;
            fmt_fill_reg  <= fill_zero_reg;
            fmt_top_reg   <= top_cur;
            fmt_n_reg     <= n_cur;
        end
        if (state_reg == ST_CONV && conv_done) begin
            fmt_bcd_reg <= conv_bcd;
            idx_reg     <= fmt_top_reg;
        end
        if (state_reg == ST_FMT && fmt_go) begin
            idx_reg <= idx_m1;
            if (fmt_blank) begin
                fmt_minus_reg <= 1'b0;
            end else begin
                fmt_bcd_reg <= fmt_bcd_reg >> 4;
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg <= 4'd4;
            fill_zero_reg   <= 1'b0;
            frac_digits_reg <= 3'd0;
            blink_en_reg    <= 1'b0;
            user_count_reg  <= 4'd0;
            user_table_reg  <= 64'd0;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                REG_DIGIT_COUNT: digit_count_reg <= pwdata[3:0];
                REG_FILL_ZERO:   fill_zero_reg   <= pwdata[0];
                REG_FRAC_DIGITS: frac_digits_reg <= pwdata[2:0];
                REG_BLINK_EN:    blink_en_reg    <= pwdata[0];
                REG_USER_COUNT:  user_count_reg  <= pwdata[3:0];
                REG_USER_TABLE:  user_table_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[5:3])
            REG_DIGIT_COUNT: prdata = {60'd0, digit_count_reg};
            REG_FILL_ZERO:   prdata = {63'd0, fill_zero_reg};
            REG_FRAC_DIGITS: prdata = {61'd0, frac_digits_reg};
            REG_BLINK_EN:    prdata = {63'd0, blink_en_reg};
            REG_USER_COUNT:  prdata = {60'd0, user_count_reg};
            REG_USER_TABLE:  prdata = user_table_reg;
            default:         prdata = 64'd0;
        endcase
    end

    assign pready = 1'b1;

    // checks
    a_wint_enters_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_start |=> state_reg == ST_CONV)
        else $error("write integer did not start conversion");

    a_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_done |-> state_reg == ST_CONV)
        else $error("converter finished outside conversion state");

    a_scan_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_data.cmd == CMD_SCAN) |=> CNT_W'(scan_pos_reg) < n_cur)
        else $error("scan position past digits in use");

    a_blink_off_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        !blink_en_reg |-> blink_phase_reg)
        else $error("display dark with blinking disabled");

endmodule
`default_nettype wire

// ----- src/ssd_bcd_conv.sv -----
// ---------------------------------------------------------------------------
// ssd_bcd_conv: serial binary to bcd converter
// Shift-and-add-3 over ten bcd digits, four magnitude bits per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module ssd_bcd_conv (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [ssd_pkg::VALUE_W-1:0] mag,
    output logic                           done,
    output logic [ssd_pkg::BCD_W-1:0]      bcd
);
    import ssd_pkg::*;

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [VALUE_W-1:0] bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [VALUE_W-1:0] bin_next;
    logic [BCD_W-1:0]   bcd_next;

    // four dependent shift-and-correct steps
    always_comb begin
        logic [BCD_W-1:0]   b;
        logic [VALUE_W-1:0] v;
        b = bcd_reg;
        v = bin_reg;
        for (int s = 0; s < CONV_BITS; s++) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (b[4*d +: 4] >= 4'd5) begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            {b, v} = {b[BCD_W-2:0], v, 1'b0};
        end
        bcd_next = b;
        bin_next = v;
    end

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CONV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            bin_reg <= mag;
            bcd_reg <= '0;
        end else if (busy_reg) begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule
`default_nettype wire

// ----- src/ssd_seg_decode.sv -----
// ---------------------------------------------------------------------------
// ssd_seg_decode: character to segment decoder
// Digits by table, minus sign, user letters from A, point from bit 7.
// ---------------------------------------------------------------------------
`default_nettype none
module ssd_seg_decode (
    input  wire logic [7:0]  char_in,
    input  wire logic [3:0]  user_count,
    input  wire logic [63:0] user_table,
    output logic [7:0]       seg
);
    import ssd_pkg::*;

    logic [6:0] ch;
    logic [6:0] letter_off;
    logic [3:0] cnt;
    logic [7:0] base;

    assign ch         = char_in[6:0];
    assign letter_off = ch - CH7_A;
    assign cnt        = (user_count > 4'd8) ? 4'd8 : user_count;

    // base pattern
    always_comb begin
        base = 8'h00;
        if (ch >= CH7_ZERO && ch <= CH7_NINE) begin
            base = digit_seg(ch[3:0]);
        end else if (ch == CH7_MINUS) begin
            base = SEG_MINUS;
        end else if (ch >= CH7_A && letter_off < {3'b000, cnt}) begin
            base = user_table[{letter_off[2:0], 3'b000} +: 8];
        end
    end

    assign seg = char_in[7] ? (base | SEG_POINT) : base;

endmodule
`default_nettype wire
